### sv/lwc_pkg.sv
// Shared types, constants and divisor tables for the Lyndon word counter.
`default_nettype none
package lwc_pkg;

	localparam int LWC_MAX_LETTERS = 63;
	localparam int LWC_MAX_PERIOD  = 10;

	localparam int LETTER_W = 6;
	localparam int PERIOD_W = 4;
	localparam int COUNT_W  = 57;
	localparam int POW_W    = 60;
	localparam int ACC_W    = 62;
	localparam int DIV_W    = 60;
	localparam int MASK_W   = 1 << PERIOD_W;

	typedef struct packed {
		logic [LETTER_W-1:0] letters;
		logic [PERIOD_W-1:0] period;
	} in_t;

	typedef struct packed {
		logic [LETTER_W-1:0] which;
		logic [COUNT_W-1:0]  count;
		logic                last;
	} out_t;

	typedef struct packed {
		logic capture;
		logic init;
		logic step;
		logic div_start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mac_done;
		logic div_done;
		logic out_free;
		logic last_item;
	} sts_t;

	// Divisors d of p whose cofactor p/d has Moebius value +1.
	function automatic logic [MASK_W-1:0] add_mask(input logic [PERIOD_W-1:0] p);
		logic [MASK_W-1:0] m;
		m = '0;
		case (p)
			4'd1:  m[1] = 1'b1;
			4'd2:  m[2] = 1'b1;
			4'd3:  m[3] = 1'b1;
			4'd4:  m[4] = 1'b1;
			4'd5:  m[5] = 1'b1;
			4'd6:  begin
				m[1] = 1'b1;
				m[6] = 1'b1;
			end
			4'd7:  m[7] = 1'b1;
			4'd8:  m[8] = 1'b1;
			4'd9:  m[9] = 1'b1;
			4'd10: begin
				m[1]  = 1'b1;
				m[10] = 1'b1;
			end
			default: m = '0;
		endcase
		return m;
	endfunction

	// Divisors d of p whose cofactor p/d has Moebius value -1.
	function automatic logic [MASK_W-1:0] sub_mask(input logic [PERIOD_W-1:0] p);
		logic [MASK_W-1:0] m;
		m = '0;
		case (p)
			4'd2:  m[1] = 1'b1;
			4'd3:  m[1] = 1'b1;
			4'd4:  m[2] = 1'b1;
			4'd5:  m[1] = 1'b1;
			4'd6:  begin
				m[2] = 1'b1;
				m[3] = 1'b1;
			end
			4'd7:  m[1] = 1'b1;
			4'd8:  m[4] = 1'b1;
			4'd9:  m[3] = 1'b1;
			4'd10: begin
				m[2] = 1'b1;
				m[5] = 1'b1;
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### sv/lyndon_word_counter_unit.sv
// Lyndon word counter top level: controller plus datapath.
//
// One request beat on req (letters b, period p) yields b+1 result beats on res:
// first the total number of Lyndon words of length p over b letters (which = 0),
// then for each k = 1..b the count of those whose largest letter is k (which = k).
// The final beat carries last; with zero letters only the total (zero) is sent.
// Letters above MAX_LETTERS and periods above MAX_PERIOD saturate; period 0 acts as 1.
//
// Each result passes through a setup step, p steps of the power multiply-accumulate
// loop, a start step for the 2-bit-per-cycle divider by p, the wait while it runs
// its 30 steps, and a hand-off step that waits while the output register is full.
// A request adds one capture step before its first result.
// req_ready is high only while no request is in work.
// Results leave through a single output register; while the receiver stalls the
// next result is computed and then held until the register frees.
// Reset clears the controller and the output valid; no clearing pass is needed.
`default_nettype none
module lyndon_word_counter_unit
	import lwc_pkg::*;
#(
	parameter int MAX_LETTERS = LWC_MAX_LETTERS,
	parameter int MAX_PERIOD  = LWC_MAX_PERIOD
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire in_t  req,
	output logic      res_valid,
	input  wire logic res_ready,
	output out_t      res
);

	cmd_t cmd;
	sts_t sts;

	lwc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lwc_dp #(
		.MAX_LETTERS (MAX_LETTERS),
		.MAX_PERIOD  (MAX_PERIOD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
`default_nettype wire

### sv/lwc_div.sv
// Radix-4 restoring divider of a wide sum by the small word length.
`default_nettype none
module lwc_div
	import lwc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DIV_W-1:0]    dividend,
	input  wire logic [PERIOD_W-1:0] divisor,
	output logic                     busy,
	output logic [DIV_W-1:0]         quotient
);

	localparam int STEPS = DIV_W / 2;
	localparam int CNT_W = $clog2(STEPS);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [PERIOD_W-1:0] dvs_q;
	logic [PERIOD_W-1:0] rem_q;

	logic [PERIOD_W:0]   t1, t2, dvs_ext;
	logic [PERIOD_W-1:0] r1, r2;
	logic                q1, q2;

	always_comb begin
		dvs_ext = {1'b0, dvs_q};
		t1 = {rem_q, dvd_q[DIV_W-1]};
		q1 = (t1 >= dvs_ext);
		r1 = q1 ? PERIOD_W'(t1 - dvs_ext) : t1[PERIOD_W-1:0];
		t2 = {r1, dvd_q[DIV_W-2]};
		q2 = (t2 >= dvs_ext);
		r2 = q2 ? PERIOD_W'(t2 - dvs_ext) : t2[PERIOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-3:0], q1, q2};
			rem_q <= r2;
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

### sv/lwc_dp.sv
// Datapath: operand registers, power multipliers, signed accumulation and result register.
`default_nettype none
module lwc_dp
	import lwc_pkg::*;
#(
	parameter int MAX_LETTERS = LWC_MAX_LETTERS,
	parameter int MAX_PERIOD  = LWC_MAX_PERIOD
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire in_t  req,
	input  wire cmd_t cmd,
	output sts_t      sts,
	input  wire logic res_ready,
	output logic      res_valid,
	output out_t      res
);

	logic [LETTER_W-1:0] b_q, k_q, hi_q, lo_q;
	logic [PERIOD_W-1:0] p_q, d_q;
	logic [POW_W-1:0]    pow_hi_q, pow_lo_q;
	logic [ACC_W-1:0]    acc_q;
	out_t                res_q;
	logic                res_valid_q;

	logic [LETTER_W-1:0] b_sat, hi_nxt, lo_nxt;
	logic [PERIOD_W-1:0] p_sat;
	logic [POW_W-1:0]    term;
	logic [ACC_W-1:0]    term_ext;
	logic [MASK_W-1:0]   amask, smask;
	logic                div_busy;
	logic [DIV_W-1:0]    quot;

	always_comb begin
		b_sat = (req.letters > LETTER_W'(MAX_LETTERS)) ? LETTER_W'(MAX_LETTERS) : req.letters;
		if (req.period == '0) begin
			p_sat = PERIOD_W'(1);
		end else if (req.period > PERIOD_W'(MAX_PERIOD)) begin
			p_sat = PERIOD_W'(MAX_PERIOD);
		end else begin
			p_sat = req.period;
		end
		hi_nxt   = (k_q == '0) ? b_q : k_q;
		lo_nxt   = (k_q == '0) ? '0 : k_q - 1'b1;
		term     = pow_hi_q - pow_lo_q;
		term_ext = ACC_W'(term);
		amask    = add_mask(p_q);
		smask    = sub_mask(p_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			b_q <= b_sat;
			p_q <= p_sat;
		end
		if (cmd.init) begin
			hi_q     <= hi_nxt;
			lo_q     <= lo_nxt;
			pow_hi_q <= POW_W'(hi_nxt);
			pow_lo_q <= POW_W'(lo_nxt);
			acc_q    <= '0;
			d_q      <= PERIOD_W'(1);
		end else if (cmd.step) begin
			pow_hi_q <= POW_W'(pow_hi_q * hi_q);
			pow_lo_q <= POW_W'(pow_lo_q * lo_q);
			d_q      <= d_q + 1'b1;
			if (amask[d_q]) begin
				acc_q <= acc_q + term_ext;
			end else if (smask[d_q]) begin
				acc_q <= acc_q - term_ext;
			end
		end
		if (cmd.emit) begin
			res_q.which <= k_q;
			res_q.count <= quot[COUNT_W-1:0];
			res_q.last  <= (k_q == b_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				k_q <= '0;
			end else if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	lwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_q[DIV_W-1:0]),
		.divisor  (p_q),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_comb begin
		sts.mac_done  = (d_q == p_q);
		sts.div_done  = !div_busy;
		sts.out_free  = !res_valid_q || res_ready;
		sts.last_item = (k_q == b_q);
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

### sv/lwc_ctrl.sv
// Controller: sequences capture, power accumulation, division and result hand-off.
`default_nettype none
module lwc_ctrl
	import lwc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_INIT  = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DIVGO = 3'd3;
	localparam logic [2:0] ST_DIVWT = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.init  = 1'b1;
				state_nxt = ST_MAC;
			end
			ST_MAC: begin
				cmd.step = 1'b1;
				if (sts.mac_done) begin
					state_nxt = ST_DIVGO;
				end
			end
			ST_DIVGO: begin
				cmd.div_start = 1'b1;
				state_nxt     = ST_DIVWT;
			end
			ST_DIVWT: begin
				if (sts.div_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = sts.last_item ? ST_IDLE : ST_INIT;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
`default_nettype wire

### sv/lwc_checker.sv
// Port-level checks for the Lyndon word counter, bound to the top level.
`default_nettype none
module lwc_checker
	import lwc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire out_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result beat changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one still in work");

	a_busy_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> !req_ready)
		else $error("ready for a request before the last beat");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res.last |=> !req_ready)
		else $error("ready for a request after a non-last beat");

endmodule

bind lyndon_word_counter_unit lwc_checker u_lwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire
